FILE: hdl/rwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock manager package
// Shared widths, command and event codes, and the request types of the
// wait-stack memories.
// ----------------------------------------------------------------------------
package rwl_pkg;

    // Number of threads that the wait stacks and the reader count can hold.
    localparam int MAX_THREADS = 16;

    localparam int CMD_W  = 2;
    localparam int TID_W  = 4;
    localparam int EV_W   = 3;
    // Counts hold up to MAX_THREADS + 1 (a writer holder plus a full stack).
    localparam int CNT_W  = $clog2(MAX_THREADS + 2);
    localparam int ADDR_W = $clog2(MAX_THREADS);

    localparam logic [CMD_W-1:0] CMD_READER_TAKE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READER_GIVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITER_TAKE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WRITER_GIVE = 2'd3;

    localparam logic [EV_W-1:0] EV_GRANTED  = 3'd0;
    localparam logic [EV_W-1:0] EV_BLOCKED  = 3'd1;
    localparam logic [EV_W-1:0] EV_RELEASED = 3'd2;
    localparam logic [EV_W-1:0] EV_RESUMED  = 3'd3;
    localparam logic [EV_W-1:0] EV_ERROR    = 3'd4;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [TID_W-1:0]  data;
    } stack_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } stack_rd_t;

endpackage

FILE: hdl/reader_writer_lock_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock manager
// Writer-preference reader-writer lock with last-in-first-out wait stacks.
// ----------------------------------------------------------------------------
// Usage: each command transaction (command, thread_id) on the cmd channel
// produces one or more result transactions (thread_id_out, event_res, last)
// on the res channel; last marks the final result of a command.
// A command is taken in S_IDLE, and its first result is loaded into the
// output register from S_EXEC once that register is free. A release that
// resumes waiters then emits one further result per cycle from S_POP while
// the output register is free, each one taken from the registered stack
// read port; the wait-stack memory read port sets that pace.
// cmd_ready is high whenever the sequencer is idle, even while a finished
// result still waits in the output register. When the receiver holds
// res_ready low, the sequencer stalls in place with its state intact and
// resumes as soon as the output register is taken.
// Reset clears the counts, the stack depths and the output valid flag at
// once; the stack memories need no clearing since an entry is only ever
// read below the current depth, i.e. after it has been written.
// A push and a later pop of the same entry always fall in different
// commands, so the write has landed before the read and no forwarding is
// needed.
// ----------------------------------------------------------------------------
module reader_writer_lock_manager
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [rwl_pkg::CMD_W-1:0]     command,
    input  logic [rwl_pkg::TID_W-1:0]     thread_id,

    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [rwl_pkg::TID_W-1:0]     thread_id_out,
    output logic [rwl_pkg::EV_W-1:0]      event_res,
    output logic                          last
);

    localparam int CNT_W  = rwl_pkg::CNT_W;
    localparam int ADDR_W = rwl_pkg::ADDR_W;

    // Sequencer states: waiting for a command, executing the command's first
    // result, and emitting resumed waiters popped from a stack.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [rwl_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [rwl_pkg::TID_W-1:0]   tid_reg, tid_next;
    logic                        pop_readers_reg, pop_readers_next;

    logic [CNT_W-1:0]            readers_reg, readers_next;
    logic [CNT_W-1:0]            writers_reg, writers_next;
    logic [CNT_W-1:0]            rdepth_reg, rdepth_next;
    logic [CNT_W-1:0]            wdepth_reg, wdepth_next;

    logic                        res_valid_reg, res_valid_next;
    logic [rwl_pkg::TID_W-1:0]   res_tid_reg;
    logic [rwl_pkg::EV_W-1:0]    res_ev_reg;
    logic                        res_last_reg;

    logic                        emit;
    logic [rwl_pkg::TID_W-1:0]   emit_tid;
    logic [rwl_pkg::EV_W-1:0]    emit_ev;
    logic                        emit_last;
    logic                        slot_free;

    logic [CNT_W-1:0]            rdepth_dec;
    logic [CNT_W-1:0]            wdepth_dec;
    logic [CNT_W-1:0]            max_cnt;

    rwl_pkg::stack_wr_t          rstack_wr, wstack_wr;
    rwl_pkg::stack_rd_t          rstack_rd, wstack_rd;
    logic [rwl_pkg::TID_W-1:0]   rstack_data, wstack_data;

    rwl_stack_mem u_reader_stack
    (
        .clk     (clk),
        .wr      (rstack_wr),
        .rd      (rstack_rd),
        .rd_data (rstack_data)
    );

    rwl_stack_mem u_writer_stack
    (
        .clk     (clk),
        .wr      (wstack_wr),
        .rd      (wstack_rd),
        .rd_data (wstack_data)
    );

    assign rdepth_dec = rdepth_reg - CNT_W'(1);
    assign wdepth_dec = wdepth_reg - CNT_W'(1);
    assign max_cnt    = CNT_W'(rwl_pkg::MAX_THREADS);

    // The output register may be loaded when it is empty or being taken.
    assign slot_free  = !res_valid_reg || res_ready;
    assign cmd_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        tid_next         = tid_reg;
        pop_readers_next = pop_readers_reg;
        readers_next     = readers_reg;
        writers_next     = writers_reg;
        rdepth_next      = rdepth_reg;
        wdepth_next      = wdepth_reg;

        rstack_wr        = '0;
        wstack_wr        = '0;
        rstack_rd        = '0;
        wstack_rd        = '0;

        emit             = 1'b0;
        emit_tid         = tid_reg;
        emit_ev          = rwl_pkg::EV_ERROR;
        emit_last        = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = command;
                    tid_next   = thread_id;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    unique case (cmd_reg)
                        rwl_pkg::CMD_READER_TAKE:
                        begin
                            if (writers_reg != '0)
                            begin
                                // A writer holds or waits: the reader queues up.
                                if (rdepth_reg < max_cnt)
                                begin
                                    rstack_wr.en   = 1'b1;
                                    rstack_wr.addr = rdepth_reg[ADDR_W-1:0];
                                    rstack_wr.data = tid_reg;
                                    rdepth_next    = rdepth_reg + CNT_W'(1);
                                    emit_ev        = rwl_pkg::EV_BLOCKED;
                                end
                            end
                            else if (readers_reg < max_cnt)
                            begin
                                readers_next = readers_reg + CNT_W'(1);
                                emit_ev      = rwl_pkg::EV_GRANTED;
                            end
                        end

                        rwl_pkg::CMD_READER_GIVE:
                        begin
                            if (readers_reg != '0)
                            begin
                                readers_next = readers_reg - CNT_W'(1);
                                emit_ev      = rwl_pkg::EV_RELEASED;
                                // The last reader out hands over to a waiting writer.
                                if (readers_reg == CNT_W'(1) && writers_reg != '0 &&
                                    wdepth_reg != '0)
                                begin
                                    wdepth_next      = wdepth_dec;
                                    wstack_rd.en     = 1'b1;
                                    wstack_rd.addr   = wdepth_dec[ADDR_W-1:0];
                                    pop_readers_next = 1'b0;
                                    emit_last        = 1'b0;
                                    state_next       = S_POP;
                                end
                            end
                        end

                        rwl_pkg::CMD_WRITER_TAKE:
                        begin
                            if (readers_reg != '0 || writers_reg != '0)
                            begin
                                if (wdepth_reg < max_cnt)
                                begin
                                    wstack_wr.en   = 1'b1;
                                    wstack_wr.addr = wdepth_reg[ADDR_W-1:0];
                                    wstack_wr.data = tid_reg;
                                    wdepth_next    = wdepth_reg + CNT_W'(1);
                                    writers_next   = writers_reg + CNT_W'(1);
                                    emit_ev        = rwl_pkg::EV_BLOCKED;
                                end
                            end
                            else
                            begin
                                writers_next = writers_reg + CNT_W'(1);
                                emit_ev      = rwl_pkg::EV_GRANTED;
                            end
                        end

                        rwl_pkg::CMD_WRITER_GIVE:
                        begin
                            // A writer holds exactly when the count exceeds the waiters.
                            if (writers_reg > wdepth_reg)
                            begin
                                writers_next = writers_reg - CNT_W'(1);
                                emit_ev      = rwl_pkg::EV_RELEASED;
                                if (wdepth_reg != '0)
                                begin
                                    wdepth_next      = wdepth_dec;
                                    wstack_rd.en     = 1'b1;
                                    wstack_rd.addr   = wdepth_dec[ADDR_W-1:0];
                                    pop_readers_next = 1'b0;
                                    emit_last        = 1'b0;
                                    state_next       = S_POP;
                                end
                                else if (rdepth_reg != '0)
                                begin
                                    // Wake every waiting reader, top of stack first.
                                    rdepth_next      = rdepth_dec;
                                    readers_next     = readers_reg + CNT_W'(1);
                                    rstack_rd.en     = 1'b1;
                                    rstack_rd.addr   = rdepth_dec[ADDR_W-1:0];
                                    pop_readers_next = 1'b1;
                                    emit_last        = 1'b0;
                                    state_next       = S_POP;
                                end
                            end
                        end

                        default:
                        begin
                            emit_ev = rwl_pkg::EV_ERROR;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                if (slot_free)
                begin
                    emit     = 1'b1;
                    emit_ev  = rwl_pkg::EV_RESUMED;
                    emit_tid = pop_readers_reg ? rstack_data : wstack_data;
                    if (pop_readers_reg && rdepth_reg != '0)
                    begin
                        // Fetch the next reader while this one is emitted.
                        rdepth_next    = rdepth_dec;
                        readers_next   = readers_reg + CNT_W'(1);
                        rstack_rd.en   = 1'b1;
                        rstack_rd.addr = rdepth_dec[ADDR_W-1:0];
                        emit_last      = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            readers_reg   <= '0;
            writers_reg   <= '0;
            rdepth_reg    <= '0;
            wdepth_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            readers_reg   <= readers_next;
            writers_reg   <= writers_next;
            rdepth_reg    <= rdepth_next;
            wdepth_reg    <= wdepth_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        tid_reg         <= tid_next;
        pop_readers_reg <= pop_readers_next;
        if (emit)
        begin
            res_tid_reg  <= emit_tid;
            res_ev_reg   <= emit_ev;
            res_last_reg <= emit_last;
        end
    end

    assign res_valid     = res_valid_reg;
    assign thread_id_out = res_tid_reg;
    assign event_res     = res_ev_reg;
    assign last          = res_last_reg;

    // Waiting writers are always part of the writer count.
    assert property (@(posedge clk) disable iff (!rst_n)
        wdepth_reg <= writers_reg)
    else $error("writer wait depth exceeds writer count");

    // Readers and a writer never hold the lock together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(readers_reg != '0 && writers_reg > wdepth_reg))
    else $error("readers and a writer hold the lock at once");

    // Outside a reader wake-up, waiting readers imply a counted writer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_POP && rdepth_reg != '0) |-> (writers_reg != '0))
    else $error("readers wait with no writer counted");

    // A command executing in S_EXEC always produces a result on the next edge
    // unless the output register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && slot_free) |=> res_valid_reg)
    else $error("executed command produced no result");

endmodule

FILE: hdl/rwl_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wait stack memory
// Single-port-write, single-port-read synchronous memory of thread ids
// with a registered read output.
// ----------------------------------------------------------------------------
module rwl_stack_mem
(
    input  logic                           clk,
    input  rwl_pkg::stack_wr_t             wr,
    input  rwl_pkg::stack_rd_t             rd,
    output logic [rwl_pkg::TID_W-1:0]      rd_data
);

    logic [rwl_pkg::TID_W-1:0] mem [rwl_pkg::MAX_THREADS];
    logic [rwl_pkg::TID_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock manager testbench
// Sends lock commands over the command channel and checks every result
// transaction against a behavioural model of the writer-preference lock.
// A short table of hand-picked commands comes first. Random episodes follow:
// well-formed take and give sequences, floods that fill the reader count and
// both wait stacks, and some noise.
// ----------------------------------------------------------------------------
module tb;
    import rwl_pkg::*;

    // Clock, reset and run length.
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 280;
    // Long receiver hold-off, long enough for the command side to back up.
    localparam int HOLD_CYCLES    = 200;
    // A release can emit MAX_THREADS + 1 results, one per cycle while the
    // receiver takes them, so this covers any trailing activity in the block.
    localparam int SETTLE_CYCLES  = 24;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DIRECTED_COUNT = 24;

    // One result transaction as the block should present it.
    typedef struct packed {
        logic [TID_W-1:0] tid;
        logic [EV_W-1:0]  ev;
        logic             last;
    } lock_event_t;

    // One row of the directed table. When typed is set, the single result is
    // known in advance and is written in the row rather than taken from the
    // model.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [TID_W-1:0] tid;
        logic             typed;
        logic [EV_W-1:0]  ev;
    } directed_row_t;

    typedef enum {
        EP_MIXED,
        EP_NOISE,
        EP_DRAIN,
        EP_READER_FLOOD,
        EP_WRITER_FLOOD,
        EP_READER_QUEUE
    } episode_t;

    typedef enum {
        RX_FREE,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    // Every input of the block starts from a known value.
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cmd_valid = 1'b0;
    logic [CMD_W-1:0] command   = CMD_READER_TAKE;
    logic [TID_W-1:0] thread_id = '0;
    logic             res_ready = 1'b0;

    logic             cmd_ready;
    logic             res_valid;
    logic [TID_W-1:0] thread_id_out;
    logic [EV_W-1:0]  event_res;
    logic             last;

    reader_writer_lock_manager u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .command       (command),
        .thread_id     (thread_id),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .thread_id_out (thread_id_out),
        .event_res     (event_res),
        .last          (last)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Lock model. Its state is updated when a command transaction is
    // accepted, so the stimulus side can also consult it to build sequences
    // that make sense for the lock as it stands.
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] readers_held    = '0;
    logic [CNT_W-1:0] writers_counted = '0;
    logic [CNT_W-1:0] reader_wait_cnt = '0;
    logic [CNT_W-1:0] writer_wait_cnt = '0;
    logic [TID_W-1:0] reader_waiting [MAX_THREADS];
    logic [TID_W-1:0] writer_waiting [MAX_THREADS];

    // Results of the command most recently modelled, and the results still
    // owed by the block, oldest first.
    lock_event_t step_events [$];
    lock_event_t owed_events [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int burst_left     = 0;
    logic hold_request = 1'b0;

    directed_row_t directed_rows [DIRECTED_COUNT];

    function automatic void note_event(input logic [TID_W-1:0] tid, input logic [EV_W-1:0] ev);
        lock_event_t item;
        item.tid  = tid;
        item.ev   = ev;
        item.last = 1'b0;
        step_events.push_back(item);
    endfunction

    // A writer holds the lock exactly when the writer count exceeds the
    // number of writers waiting.
    function automatic bit writer_holds();
        return writers_counted > writer_wait_cnt;
    endfunction

    function automatic logic [TID_W-1:0] random_tid();
        return TID_W'($urandom_range(0, 15));
    endfunction

    task automatic lock_predict(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid);
        step_events.delete();
        case (cmd)
            CMD_READER_TAKE:
            begin
                // A counted writer, holding or waiting, makes readers wait.
                if (writers_counted != 0)
                begin
                    if (reader_wait_cnt >= MAX_THREADS)
                    begin
                        note_event(tid, EV_ERROR);
                    end
                    else
                    begin
                        reader_waiting[reader_wait_cnt[ADDR_W-1:0]] = tid;
                        reader_wait_cnt++;
                        note_event(tid, EV_BLOCKED);
                    end
                end
                else if (readers_held >= MAX_THREADS)
                begin
                    note_event(tid, EV_ERROR);
                end
                else
                begin
                    readers_held++;
                    note_event(tid, EV_GRANTED);
                end
            end
            CMD_READER_GIVE:
            begin
                if (readers_held == 0)
                begin
                    note_event(tid, EV_ERROR);
                end
                else
                begin
                    readers_held--;
                    note_event(tid, EV_RELEASED);
                    // The last reader out hands over to the newest waiting writer.
                    if (readers_held == 0 && writers_counted != 0 && writer_wait_cnt != 0)
                    begin
                        writer_wait_cnt--;
                        note_event(writer_waiting[writer_wait_cnt[ADDR_W-1:0]], EV_RESUMED);
                    end
                end
            end
            CMD_WRITER_TAKE:
            begin
                if (readers_held != 0 || writers_counted != 0)
                begin
                    if (writer_wait_cnt >= MAX_THREADS)
                    begin
                        note_event(tid, EV_ERROR);
                    end
                    else
                    begin
                        writer_waiting[writer_wait_cnt[ADDR_W-1:0]] = tid;
                        writer_wait_cnt++;
                        writers_counted++;
                        note_event(tid, EV_BLOCKED);
                    end
                end
                else
                begin
                    writers_counted++;
                    note_event(tid, EV_GRANTED);
                end
            end
            default:
            begin
                if (!writer_holds())
                begin
                    note_event(tid, EV_ERROR);
                end
                else
                begin
                    writers_counted--;
                    note_event(tid, EV_RELEASED);
                    // Writers take precedence; only with none waiting are all
                    // the waiting readers woken, newest first.
                    if (writer_wait_cnt != 0)
                    begin
                        writer_wait_cnt--;
                        note_event(writer_waiting[writer_wait_cnt[ADDR_W-1:0]], EV_RESUMED);
                    end
                    else
                    begin
                        while (reader_wait_cnt != 0)
                        begin
                            reader_wait_cnt--;
                            readers_held++;
                            note_event(reader_waiting[reader_wait_cnt[ADDR_W-1:0]],
                                       EV_RESUMED);
                        end
                    end
                end
            end
        endcase
        step_events[step_events.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Command side. Each call offers one transaction and holds it until it is
    // accepted, then records what the block owes for it. Transactions go out
    // in bursts of random length; between bursts valid drops for a random
    // gap. Within a burst valid simply stays high for the next transaction.
    // ------------------------------------------------------------------------
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid,
                         input logic typed, input logic [EV_W-1:0] typed_ev);
        lock_event_t item;
        cmd_valid <= 1'b1;
        command   <= cmd;
        thread_id <= tid;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        lock_predict(cmd, tid);
        if (typed)
        begin
            item.tid  = tid;
            item.ev   = typed_ev;
            item.last = 1'b1;
            owed_events.push_back(item);
        end
        else
        begin
            foreach (step_events[i])
            begin
                owed_events.push_back(step_events[i]);
            end
        end
        items_sent++;
        if (burst_left != 0)
        begin
            burst_left--;
        end
        else
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid);
        issue(cmd, tid, 1'b0, EV_GRANTED);
    endtask

    // Stops offering and waits until the block has delivered every result
    // that it owes.
    task automatic wait_for_results();
        cmd_valid <= 1'b0;
        while (owed_events.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Gives back whatever is held until the lock is free with nobody waiting.
    // Waiting threads are woken by the gives, so this always ends.
    task automatic drain_lock();
        while (readers_held != 0 || writers_counted != 0)
        begin
            if (writer_holds())
            begin
                offer(CMD_WRITER_GIVE, random_tid());
            end
            else
            begin
                offer(CMD_READER_GIVE, random_tid());
            end
        end
    endtask

    task automatic run_episode(input episode_t kind);
        int n;
        int r;
        logic [CMD_W-1:0] cmd;
        case (kind)
            EP_MIXED:
            begin
                // Mostly sensible traffic: takes of either kind, and gives
                // steered towards a kind of lock that is actually held.
                n = $urandom_range(8, 24);
                for (int i = 0; i < n; i++)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 3)
                    begin
                        offer(CMD_READER_TAKE, random_tid());
                    end
                    else if (r < 5)
                    begin
                        offer(CMD_WRITER_TAKE, random_tid());
                    end
                    else if (r < 8)
                    begin
                        if (readers_held != 0)
                            offer(CMD_READER_GIVE, random_tid());
                        else if (writer_holds())
                            offer(CMD_WRITER_GIVE, random_tid());
                        else
                            offer(CMD_READER_TAKE, random_tid());
                    end
                    else
                    begin
                        if (writer_holds())
                            offer(CMD_WRITER_GIVE, random_tid());
                        else if (readers_held != 0)
                            offer(CMD_READER_GIVE, random_tid());
                        else
                            offer(CMD_WRITER_TAKE, random_tid());
                    end
                end
            end
            EP_NOISE:
            begin
                n = $urandom_range(4, 12);
                for (int i = 0; i < n; i++)
                begin
                    cmd = CMD_W'($urandom_range(0, 3));
                    offer(cmd, random_tid());
                end
            end
            EP_DRAIN:
            begin
                drain_lock();
            end
            EP_READER_FLOOD:
            begin
                // Fills the reader count; the final take finds it full.
                drain_lock();
                repeat (MAX_THREADS + 1) offer(CMD_READER_TAKE, random_tid());
            end
            EP_WRITER_FLOOD:
            begin
                // One holder and a full writer stack; the final take is
                // refused. Draining then passes the lock down the stack.
                drain_lock();
                offer(CMD_WRITER_TAKE, random_tid());
                repeat (MAX_THREADS + 1) offer(CMD_WRITER_TAKE, random_tid());
                drain_lock();
            end
            default:
            begin
                // A full reader stack behind one writer. The final give wakes
                // every waiting reader, which is the longest result sequence.
                drain_lock();
                offer(CMD_WRITER_TAKE, random_tid());
                repeat (MAX_THREADS + 1) offer(CMD_READER_TAKE, random_tid());
                offer(CMD_WRITER_GIVE, random_tid());
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result side. Each accepted result transaction is checked against the
    // oldest one owed. The receiver changes its stall pattern every so often,
    // and once, on request, holds off for a long stretch that it counts
    // itself.
    // ------------------------------------------------------------------------
    rx_mode_t rx_mode      = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_phase     = 0;
    int       hold_left    = 0;
    bit       hold_taken   = 1'b0;

    task automatic check_result();
        lock_event_t owed;
        if (owed_events.size() == 0)
        begin
            $display("%0t: unexpected result: thread %0d event %0d last %0d",
                     $time, thread_id_out, event_res, last);
            mismatch_count++;
        end
        else
        begin
            owed = owed_events.pop_front();
            if (thread_id_out !== owed.tid)
            begin
                $display("%0t: thread_id_out mismatch: expected %0d, actual %0d",
                         $time, owed.tid, thread_id_out);
                mismatch_count++;
            end
            if (event_res !== owed.ev)
            begin
                $display("%0t: event_res mismatch: expected %0d, actual %0d",
                         $time, owed.ev, event_res);
                mismatch_count++;
            end
            if (last !== owed.last)
            begin
                $display("%0t: last mismatch: expected %0d, actual %0d",
                         $time, owed.last, last);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            check_result();
        end
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 120);
        end
        else
        begin
            rx_mode_left--;
        end
        rx_phase++;
        if (hold_left != 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            res_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:    res_ready <= 1'b1;
                RX_COIN:    res_ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: res_ready <= (rx_phase % 4) != 3;
                default:    res_ready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Run watchdog: a run that has not ended by this count has hung.
    // ------------------------------------------------------------------------
    int watchdog_cycles;

    initial
    begin
        for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
        begin
            @(posedge clk);
        end
        $display("reader_writer_lock_manager test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int pick;
        // Directed table. It opens with gives on an empty lock, then walks
        // through blocking behind readers and writers, handover from the last
        // reader to the newest waiting writer, writer-to-writer handover, and
        // a writer give that wakes every waiting reader newest first.
        directed_rows = '{
            '{CMD_READER_GIVE, 4'd3,  1'b1, EV_ERROR},
            '{CMD_WRITER_GIVE, 4'd5,  1'b1, EV_ERROR},
            '{CMD_READER_TAKE, 4'd0,  1'b1, EV_GRANTED},
            '{CMD_READER_TAKE, 4'd15, 1'b0, EV_GRANTED},
            '{CMD_WRITER_TAKE, 4'd7,  1'b0, EV_GRANTED},
            '{CMD_READER_TAKE, 4'd9,  1'b0, EV_GRANTED},
            // Only a waiting writer is counted, so nobody holds the write lock.
            '{CMD_WRITER_GIVE, 4'd2,  1'b1, EV_ERROR},
            '{CMD_WRITER_TAKE, 4'd12, 1'b0, EV_GRANTED},
            '{CMD_READER_GIVE, 4'd0,  1'b0, EV_GRANTED},
            '{CMD_READER_GIVE, 4'd15, 1'b0, EV_GRANTED},
            '{CMD_READER_TAKE, 4'd1,  1'b0, EV_GRANTED},
            '{CMD_WRITER_GIVE, 4'd12, 1'b0, EV_GRANTED},
            '{CMD_READER_GIVE, 4'd4,  1'b1, EV_ERROR},
            '{CMD_WRITER_GIVE, 4'd7,  1'b0, EV_GRANTED},
            '{CMD_WRITER_TAKE, 4'd14, 1'b0, EV_GRANTED},
            '{CMD_READER_GIVE, 4'd1,  1'b0, EV_GRANTED},
            '{CMD_READER_GIVE, 4'd9,  1'b0, EV_GRANTED},
            '{CMD_WRITER_TAKE, 4'd8,  1'b0, EV_GRANTED},
            '{CMD_WRITER_GIVE, 4'd14, 1'b0, EV_GRANTED},
            '{CMD_WRITER_GIVE, 4'd8,  1'b0, EV_GRANTED},
            '{CMD_WRITER_TAKE, 4'd0,  1'b0, EV_GRANTED},
            '{CMD_WRITER_GIVE, 4'd15, 1'b0, EV_GRANTED},
            '{CMD_READER_TAKE, 4'd15, 1'b0, EV_GRANTED},
            '{CMD_READER_GIVE, 4'd15, 1'b0, EV_GRANTED}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIRECTED_COUNT; row++)
        begin
            issue(directed_rows[row].cmd, directed_rows[row].tid,
                  directed_rows[row].typed, directed_rows[row].ev);
        end

        // Let the block empty completely before the random part.
        wait_for_results();

        // The full-stack and full-count cases are forced once each. During the
        // writer flood the receiver holds off for a long stretch while the
        // sender keeps offering without gaps, so the block backs up.
        run_episode(EP_READER_QUEUE);
        hold_request <= 1'b1;
        burst_left = 40;
        run_episode(EP_WRITER_FLOOD);
        run_episode(EP_READER_FLOOD);

        while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                run_episode(EP_MIXED);
            else if (pick < 11)
                run_episode(EP_NOISE);
            else if (pick < 14)
                run_episode(EP_DRAIN);
            else if (pick < 16)
                run_episode(EP_READER_FLOOD);
            else if (pick < 18)
                run_episode(EP_WRITER_FLOOD);
            else
                run_episode(EP_READER_QUEUE);
            if ($urandom_range(0, 4) == 0)
            begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("reader_writer_lock_manager test passed");
        end
        else
        begin
            $display("reader_writer_lock_manager test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/rwl_pkg.sv
hdl/rwl_stack_mem.sv
hdl/reader_writer_lock_manager.sv
tb/tb.sv
